>>> sv/sczalloc_pkg.sv
// shared types and constants for the size-class zone allocator
`timescale 1ns / 1ps

package sczalloc_pkg;

    // field widths of the request and result ports
    localparam int SIZE_W   = 21;
    localparam int OFFS_W   = 20;
    localparam int CLASS_W  = 5;
    localparam int STATUS_W = 2;

    // class size table build constants
    localparam int GROWTH_NUM   = 1657;
    localparam int GROWTH_SHIFT = 10;
    localparam int FIRST_CLASS  = 4;
    localparam int RESET_CAPACITY = 65536;

    // request operation codes
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_SIZE   = 2'd1,
        ST_NO_MEMORY  = 2'd2,
        ST_STACK_FULL = 2'd3
    } t_status;

endpackage

>>> sv/size_class_zone_allocator.sv
// size-class zone allocator: class table build, class search and free stacks
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+---------------------------
//   request  | i_operation, i_request_size, i_block_offset    | start high, busy low
//   result   | o_status, o_granted_offset, o_class_chosen,    | o_valid for one cycle
//            | o_bytes_in_use                                 |
//   config   | i_cfg_wr_data (zone capacity)                  | i_cfg_wr_en
//
// clear, unused and zero-size requests answer in the cycle after start.
// allocate and free answer after the scale state, the class search and the execute state,
// with the search making one compare per cycle up to the chosen class; a pop from a free stack
// adds a state for the registered stack read.
// reset or a capacity write rebuilds the class table with one shared multiplier, stepping
// each class through the align, scale, grow and next states; busy stays high meanwhile.
// the receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module size_class_zone_allocator
    import sczalloc_pkg::*;
#(
    parameter int MAX_CLASSES  = 32,
    parameter int STACK_DEPTH  = 16,
    parameter int ALIGN_BYTES  = 8,
    parameter int MAX_CAPACITY = 1048576
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_operation,
    input  logic [SIZE_W-1:0]   i_request_size,
    input  logic [OFFS_W-1:0]   i_block_offset,
    input  logic                i_cfg_wr_en,
    input  logic [SIZE_W-1:0]   i_cfg_wr_data,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [OFFS_W-1:0]   o_granted_offset,
    output logic [CLASS_W-1:0]  o_class_chosen,
    output logic [SIZE_W-1:0]   o_bytes_in_use
);

    localparam int CIW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int TW     = $clog2(MAX_CLASSES + 1);
    localparam int FW     = $clog2(STACK_DEPTH + 1);
    localparam int MEM_N  = MAX_CLASSES * STACK_DEPTH;
    localparam int AW     = (MEM_N > 1) ? $clog2(MEM_N) : 1;
    localparam int CLS_W  = SIZE_W + 1;
    localparam int RSH    = 28;
    localparam int MA_W   = RSH + 1;
    localparam int MB_W   = SIZE_W + 1;
    localparam int P_W    = MA_W + MB_W;
    localparam logic [MA_W-1:0] RECIP =
        MA_W'(((64'd1 << RSH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
    localparam logic [MB_W-1:0] ALIGN_M1 = MB_W'(ALIGN_BYTES - 1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_BALIGN  = 9'b000000010,
        S_BSCALE  = 9'b000000100,
        S_BGROW   = 9'b000001000,
        S_BNEXT   = 9'b000010000,
        S_RSCALE  = 9'b000100000,
        S_RSEARCH = 9'b001000000,
        S_REXEC   = 9'b010000000,
        S_RPOP    = 9'b100000000
    } t_state;

    t_state              r_state;
    logic [SIZE_W-1:0]   r_cap;
    logic [CLS_W-1:0]    r_class [MAX_CLASSES];
    logic [TW-1:0]       r_total;
    logic [FW-1:0]       r_fill  [MAX_CLASSES];
    logic [SIZE_W-1:0]   r_used;
    logic [SIZE_W-1:0]   r_bump;
    logic [MB_W-1:0]     r_cur;
    logic [CIW-1:0]      r_n;
    logic [CIW-1:0]      r_cls;
    logic [P_W-1:0]      r_prod;
    logic [1:0]          r_op;
    logic [OFFS_W-1:0]   r_offs;
    logic                r_valid;
    logic [STATUS_W-1:0] r_status;
    logic [OFFS_W-1:0]   r_granted;
    logic [OFFS_W-1:0]   r_mem [MEM_N];
    logic [OFFS_W-1:0]   r_rd;

    logic [MA_W-1:0]     mul_a;
    logic [MB_W-1:0]     mul_b;
    logic                mul_en;
    logic [MB_W-1:0]     quot;
    logic [CLS_W-1:0]    aligned;
    logic [CLS_W-1:0]    cs;
    logic [FW-1:0]       fill;
    logic [SIZE_W+1:0]   used_sum;
    logic [SIZE_W+1:0]   bump_sum;
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [FW-1:0]       slot;
    logic [SIZE_W-1:0]   cfg_cap;

    assign quot    = r_prod[RSH +: MB_W];
    assign aligned = r_prod[CLS_W-1:0];
    assign cs      = r_class[r_cls];
    assign fill    = r_fill[r_cls];
    assign used_sum = (SIZE_W + 2)'(r_used) + (SIZE_W + 2)'(cs);
    assign bump_sum = (SIZE_W + 2)'(r_bump) + (SIZE_W + 2)'(cs);

    // capacity write saturates at the zone maximum
    assign cfg_cap = (32'(i_cfg_wr_data) > 32'(MAX_CAPACITY)) ?
                     SIZE_W'(MAX_CAPACITY) : i_cfg_wr_data;

    // shared multiplier operand select
    always_comb begin
        mul_a  = RECIP;
        mul_b  = MB_W'(i_request_size) + ALIGN_M1;
        mul_en = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                mul_en = 1'b1;
            end
            S_BALIGN: begin
                mul_b  = r_cur + ALIGN_M1;
                mul_en = 1'b1;
            end
            S_BSCALE, S_RSCALE: begin
                mul_a  = MA_W'(ALIGN_BYTES);
                mul_b  = quot;
                mul_en = 1'b1;
            end
            S_BGROW: begin
                mul_a  = MA_W'(GROWTH_NUM);
                mul_b  = r_cur;
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // free stack addressing: pop reads the top entry, push writes above it
    always_comb begin
        slot     = (r_op == OP_ALLOC) ? (fill - FW'(1)) : fill;
        mem_addr = AW'(32'(r_cls) * STACK_DEPTH) + AW'(slot);
        mem_we   = (r_state == S_REXEC) && (r_op == OP_FREE) &&
                   (32'(fill) < STACK_DEPTH);
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_offs;
        end
        r_rd <= r_mem[mem_addr];
    end

    // shared multiplier result register
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= P_W'(mul_a) * P_W'(mul_b);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_BALIGN;
            r_cap    <= SIZE_W'(RESET_CAPACITY);
            r_cur    <= MB_W'(FIRST_CLASS);
            r_n      <= '0;
            r_total  <= '0;
            r_used   <= '0;
            r_bump   <= '0;
            r_cls    <= '0;
            r_valid  <= 1'b0;
            r_status <= ST_OK;
            r_granted <= '0;
            r_op     <= OP_NONE;
            for (int i = 0; i < MAX_CLASSES; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_wr_en) begin
                        // new capacity: clear the zone and rebuild the table
                        r_cap   <= cfg_cap;
                        r_cur   <= MB_W'(FIRST_CLASS);
                        r_n     <= '0;
                        r_used  <= '0;
                        r_bump  <= '0;
                        for (int i = 0; i < MAX_CLASSES; i++) begin
                            r_fill[i] <= '0;
                        end
                        r_state <= S_BALIGN;
                    end else if (start) begin
                        r_op      <= i_operation;
                        r_offs    <= i_block_offset;
                        r_cls     <= '0;
                        r_granted <= '0;
                        r_status  <= ST_OK;
                        case (i_operation)
                            OP_CLEAR: begin
                                r_used  <= '0;
                                r_bump  <= '0;
                                for (int i = 0; i < MAX_CLASSES; i++) begin
                                    r_fill[i] <= '0;
                                end
                                r_valid <= 1'b1;
                            end
                            OP_NONE: begin
                                r_valid <= 1'b1;
                            end
                            default: begin
                                if (i_request_size == '0) begin
                                    r_status <= ST_BAD_SIZE;
                                    r_valid  <= 1'b1;
                                end else begin
                                    r_state <= S_RSCALE;
                                end
                            end
                        endcase
                    end
                end
                // table build: align, scale, store, grow
                S_BALIGN: begin
                    if ((r_cur <= MB_W'(r_cap)) && (32'(r_n) < MAX_CLASSES - 1)) begin
                        r_state <= S_BSCALE;
                    end else begin
                        r_class[r_n] <= CLS_W'(r_cap);
                        r_total      <= TW'(r_n) + TW'(1);
                        r_state      <= S_IDLE;
                    end
                end
                S_BSCALE: begin
                    r_state <= S_BGROW;
                end
                S_BGROW: begin
                    r_class[r_n] <= aligned;
                    r_state      <= S_BNEXT;
                end
                S_BNEXT: begin
                    r_cur   <= r_prod[GROWTH_SHIFT +: MB_W];
                    r_n     <= r_n + CIW'(1);
                    r_state <= S_BALIGN;
                end
                // request path: align size, then search classes one per cycle
                S_RSCALE: begin
                    r_state <= S_RSEARCH;
                end
                S_RSEARCH: begin
                    if ((r_class[r_cls] >= aligned) ||
                        (TW'(r_cls) == r_total - TW'(1))) begin
                        r_state <= S_REXEC;
                    end else begin
                        r_cls <= r_cls + CIW'(1);
                    end
                end
                S_REXEC: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b1;
                    if (r_op == OP_ALLOC) begin
                        if (used_sum > (SIZE_W + 2)'(r_cap)) begin
                            r_status <= ST_NO_MEMORY;
                        end else if (fill != '0) begin
                            r_fill[r_cls] <= fill - FW'(1);
                            r_used  <= SIZE_W'(used_sum);
                            r_valid <= 1'b0;
                            r_state <= S_RPOP;
                        end else if (bump_sum > (SIZE_W + 2)'(r_cap)) begin
                            r_status <= ST_NO_MEMORY;
                        end else begin
                            r_granted <= OFFS_W'(r_bump);
                            r_bump    <= SIZE_W'(bump_sum);
                            r_used    <= SIZE_W'(used_sum);
                        end
                    end else begin
                        if (32'(fill) >= STACK_DEPTH) begin
                            r_status <= ST_STACK_FULL;
                        end else begin
                            r_fill[r_cls] <= fill + FW'(1);
                            r_used <= ((SIZE_W + 1)'(r_used) > (SIZE_W + 1)'(cs)) ?
                                      SIZE_W'((SIZE_W + 1)'(r_used) - (SIZE_W + 1)'(cs)) :
                                      '0;
                        end
                    end
                end
                S_RPOP: begin
                    r_granted <= r_rd;
                    r_valid   <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_granted_offset = r_granted;
    assign o_class_chosen   = CLASS_W'(r_cls);
    assign o_bytes_in_use   = r_used;

endmodule

>>> sv/sczalloc_checker.sv
// port-level checks for the size-class zone allocator, bound to the top level
`timescale 1ns / 1ps

module sczalloc_checker
    import sczalloc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                i_cfg_wr_en,
    input logic                o_valid,
    input logic [STATUS_W-1:0] o_status,
    input logic [OFFS_W-1:0]   o_granted_offset,
    input logic [CLASS_W-1:0]  o_class_chosen
);

    // an accepted request either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_wr_en) |=> (o_valid || busy))
        else $error("accepted request neither answered nor busy");

    // a result is shown only once the sequencer is back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // a capacity write starts a table rebuild
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wr_en && !busy) |=> busy)
        else $error("capacity write did not start rebuild");

    // failed requests grant nothing
    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_granted_offset == '0))
        else $error("offset granted on a failed request");

    // an invalid size maps to no class
    a_bad_size_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_BAD_SIZE) |-> (o_class_chosen == '0))
        else $error("class reported for an invalid size");

endmodule

bind size_class_zone_allocator sczalloc_checker u_sczalloc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_cfg_wr_en      (i_cfg_wr_en),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_granted_offset (o_granted_offset),
    .o_class_chosen   (o_class_chosen)
);
